// File: hdl/kva_pkg.sv
// Shared constants and types for the key-matrix voice allocator.
// No dependencies; every other file of the block imports this package.
package kva_pkg;

   localparam int NUM_VOICES_DEF  = 9;
   localparam int NUM_COLUMNS_DEF = 6;
   localparam int NUM_ROWS_DEF    = 7;

   localparam int COL_IDX_W  = 3;
   localparam int ROW_BITS_W = 7;
   localparam int VOICE_W    = 4;
   localparam int NOTE_W     = 7;
   localparam int NOTE_SUM_W = 11;

   localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd46;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_WORD_W = CSR_ADDR_W - 2;

   // Register indexes (word address)
   localparam logic [CSR_WORD_W-1:0] REG_BASE_NOTE = 1'b0;

   typedef struct packed {
      logic               found;
      logic [VOICE_W-1:0] voice;
   } voice_pick_type;

endpackage

// File: hdl/kva_req_if.sv
// Scan-column request channel: valid/ready handshake plus one column word.
// Depends on kva_pkg for field widths.
interface kva_req_if import kva_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COL_IDX_W-1:0]  column_index;
   logic [ROW_BITS_W-1:0] row_bits;

   modport source (output valid, output column_index, output row_bits, input ready);
   modport sink   (input valid, input column_index, input row_bits, output ready);
endinterface

// File: hdl/kva_rsp_if.sv
// Key event response channel: valid/ready handshake plus one event word.
// Depends on kva_pkg for field widths.
interface kva_rsp_if import kva_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               note_on;
   logic [VOICE_W-1:0] voice;
   logic [NOTE_W-1:0]  note;
   logic               last;

   modport source (output valid, output note_on, output voice, output note, output last,
                   input ready);
   modport sink   (input valid, input note_on, input voice, input note, input last,
                   output ready);
endinterface

// File: hdl/key_matrix_voice_allocator.sv
// Key-matrix voice allocator. Each accepted request word is one scanned column; the block
// walks its rows one per cycle from row 0, gives a newly pressed key the next free voice
// round-robin and releases the voice of a let-go key, sending one event word per change
// with last set on the final one. A column is accepted, walked through the row sequencer
// row by row and then closed; a column index beyond the matrix is accepted and sends
// nothing. Events are held back one word so that last can be marked; a stalled response
// port stalls the row walk.
// Depends on kva_pkg, kva_req_if, kva_rsp_if, kva_csr and kva_voice_pick.
module key_matrix_voice_allocator import kva_pkg::*; #(
   parameter int NUM_VOICES  = NUM_VOICES_DEF,
   parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
   parameter int NUM_ROWS    = NUM_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   kva_req_if.sink               req_chan,
   kva_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ROWS_USED = (NUM_ROWS < ROW_BITS_W) ? NUM_ROWS : ROW_BITS_W;
   localparam int ROW_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
   localparam int COL_W     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int VIDX_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]            state_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [COL_IDX_W-1:0]  col_ff;
   logic [ROWS_USED-1:0]  bits_ff;

   // per-column key map: held flags reset, voice fields written before use
   logic [ROWS_USED-1:0]  map_held_ff  [NUM_COLUMNS];
   logic [VOICE_W-1:0]    map_voice_ff [NUM_COLUMNS][ROWS_USED];

   // working copy of the current column, one lane per row
   logic [ROWS_USED-1:0]  work_held_ff;
   logic [VOICE_W-1:0]    work_voice_ff [ROWS_USED];

   logic [NUM_VOICES-1:0] busy_ff;
   logic [VOICE_W-1:0]    last_given_ff;

   logic                  pend_valid_ff;
   logic                  pend_note_on_ff;
   logic [VOICE_W-1:0]    pend_voice_ff;
   logic [NOTE_W-1:0]     pend_note_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_note_on_ff;
   logic [VOICE_W-1:0]    rsp_voice_ff;
   logic [NOTE_W-1:0]     rsp_note_ff;
   logic                  rsp_last_ff;

   logic [NOTE_W-1:0]     base_note;
   voice_pick_type        pick;

   logic                  req_fire;
   logic                  col_ok;
   logic [COL_W-1:0]      req_col;
   logic [COL_W-1:0]      cur_col;
   logic                  cur_held;
   logic [VOICE_W-1:0]    cur_voice;
   logic                  cur_press;
   logic                  press_ev;
   logic                  release_ev;
   logic                  any_ev;
   logic                  out_free;
   logic                  scan_go;
   logic                  push_mid;
   logic                  push_end;
   logic                  flush_done;
   logic [NOTE_SUM_W-1:0] note_sum;

   kva_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .base_note   (base_note)
   );

   kva_voice_pick #(.NUM_VOICES(NUM_VOICES)) u_voice_pick (
      .busy       (busy_ff),
      .last_given (last_given_ff),
      .pick       (pick)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign col_ok         = 32'(req_chan.column_index) < NUM_COLUMNS;
   assign req_col        = COL_W'(req_chan.column_index);
   assign cur_col        = COL_W'(col_ff);

   assign cur_held   = work_held_ff[row_ff];
   assign cur_voice  = work_voice_ff[row_ff];
   assign cur_press  = bits_ff[row_ff];
   assign press_ev   = (state_ff == ST_SCAN) && cur_press && !cur_held && pick.found;
   assign release_ev = (state_ff == ST_SCAN) && cur_held && !cur_press;
   assign any_ev     = press_ev || release_ev;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign scan_go    = (state_ff == ST_SCAN) && !(any_ev && pend_valid_ff && !out_free);
   assign push_mid   = scan_go && any_ev && pend_valid_ff;
   assign push_end   = (state_ff == ST_FLUSH) && pend_valid_ff && out_free;
   assign flush_done = (state_ff == ST_FLUSH) && (!pend_valid_ff || out_free);

   assign note_sum = NOTE_SUM_W'(row_ff) * NOTE_SUM_W'(NUM_COLUMNS)
                   + NOTE_SUM_W'(col_ff) + NOTE_SUM_W'(base_note);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         busy_ff       <= '0;
         last_given_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            map_held_ff[c] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && col_ok) begin
                  state_ff <= ST_SCAN;
                  row_ff   <= '0;
               end
            end
            ST_SCAN: begin
               if (scan_go) begin
                  if (press_ev) begin
                     busy_ff[pick.voice[VIDX_W-1:0]] <= 1'b1;
                     last_given_ff                   <= pick.voice;
                  end else if (release_ev) begin
                     busy_ff[cur_voice[VIDX_W-1:0]] <= 1'b0;
                  end
                  if (any_ev) begin
                     pend_valid_ff <= 1'b1;
                  end
                  if (row_ff == ROW_W'(ROWS_USED - 1)) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end
            end
            ST_FLUSH: begin
               if (flush_done) begin
                  pend_valid_ff        <= 1'b0;
                  map_held_ff[cur_col] <= work_held_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (push_mid || push_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         col_ff  <= req_chan.column_index;
         bits_ff <= req_chan.row_bits[ROWS_USED-1:0];
         if (col_ok) begin
            work_held_ff <= map_held_ff[req_col];
            for (int r = 0; r < ROWS_USED; r++) begin
               work_voice_ff[r] <= map_voice_ff[req_col][r];
            end
         end
      end

      if (scan_go && press_ev) begin
         work_held_ff[row_ff]  <= 1'b1;
         work_voice_ff[row_ff] <= pick.voice;
      end else if (scan_go && release_ev) begin
         work_held_ff[row_ff]  <= 1'b0;
         work_voice_ff[row_ff] <= '0;
      end

      // hold each event back one word so the final one can carry last
      if (scan_go && any_ev) begin
         pend_note_on_ff <= press_ev;
         pend_voice_ff   <= press_ev ? pick.voice : cur_voice;
         pend_note_ff    <= note_sum[NOTE_W-1:0];
      end

      if (push_mid || push_end) begin
         rsp_note_on_ff <= pend_note_on_ff;
         rsp_voice_ff   <= pend_voice_ff;
         rsp_note_ff    <= pend_note_ff;
         rsp_last_ff    <= push_end;
      end

      if (flush_done) begin
         for (int r = 0; r < ROWS_USED; r++) begin
            map_voice_ff[cur_col][r] <= work_voice_ff[r];
         end
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.note_on = rsp_note_on_ff;
   assign rsp_chan.voice   = rsp_voice_ff;
   assign rsp_chan.note    = rsp_note_ff;
   assign rsp_chan.last    = rsp_last_ff;

   a_last_given_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, last_given_ff} < (VOICE_W + 1)'(NUM_VOICES))
      else $error("last given voice out of range");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending event left over after column closed");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push_mid || push_end) |-> out_free)
      else $error("event pushed into occupied output register");

   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && !pend_valid_ff) |=> (state_ff == ST_IDLE))
      else $error("column close did not return to idle");

endmodule

// File: hdl/kva_csr.sv
// APB-style register port holding the base note register.
// Depends on kva_pkg for address decode and reset value.
module kva_csr import kva_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [NOTE_W-1:0]     base_note
);

   logic [NOTE_W-1:0]     base_note_ff;
   logic [CSR_WORD_W-1:0] word_addr;
   logic                  wr_en;

   assign word_addr  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff <= BASE_NOTE_RESET;
      end else if (wr_en && word_addr == REG_BASE_NOTE) begin
         base_note_ff <= csr_pwdata[NOTE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (word_addr == REG_BASE_NOTE) begin
         csr_prdata = CSR_DATA_W'(base_note_ff);
      end
   end

   assign base_note = base_note_ff;

endmodule

// File: hdl/kva_voice_pick.sv
// Round-robin free-voice search: one lane per voice flags a free voice, then a
// merge picks the first one at or after the start point, else the lowest. Uses kva_pkg.
module kva_voice_pick import kva_pkg::*; #(
   parameter int NUM_VOICES = NUM_VOICES_DEF
) (
   input  logic [NUM_VOICES-1:0] busy,
   input  logic [VOICE_W-1:0]    last_given,
   output voice_pick_type        pick
);

   logic [VOICE_W-1:0] start;
   logic               hi_found;
   logic               lo_found;
   logic [VOICE_W-1:0] hi_voice;
   logic [VOICE_W-1:0] lo_voice;

   always_comb begin
      start    = (last_given == VOICE_W'(NUM_VOICES - 1)) ? '0 : last_given + 1'b1;
      hi_found = 1'b0;
      lo_found = 1'b0;
      hi_voice = '0;
      lo_voice = '0;
      // walk down so the lowest matching voice wins
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (!busy[v]) begin
            lo_found = 1'b1;
            lo_voice = VOICE_W'(v);
            if (VOICE_W'(v) >= start) begin
               hi_found = 1'b1;
               hi_voice = VOICE_W'(v);
            end
         end
      end
      pick.found = lo_found;
      pick.voice = hi_found ? hi_voice : lo_voice;
   end

endmodule
